@@ src/bdq_pkg.sv @@
package bdq_pkg;

    // Store geometry
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Opcodes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [6:0] count;
        logic       is_empty;
    } t_out_word;

endpackage

@@ src/bounded_deque_with_search.sv @@
// Channel  | Direction | Signals                               | Word
// ---------+-----------+---------------------------------------+-----------
// in       | input     | i_in_valid, o_in_ready, i_in_word     | t_in_word
// out      | output    | o_out_valid, i_out_ready, o_out_word  | t_out_word
//
// Pushes, pops and unused opcodes complete in S_IDLE and produce a registered result word.
// A search reads the element store one word per cycle through its registered read port,
// comparing each word with the key; it stops at the first match.
// Synchronous active-low reset empties the deque; the store itself is not cleared.
// A result waits in the output register while the next word is taken; a second
// finished result parks in a pending register and input stalls until it moves out.
module bounded_deque_with_search
    import bdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_HOLD   = 3'b100
    } t_state;

    // Position off entries after base, wrapped into the store
    function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic             r_rd_vld, n_rd_vld;
    logic [31:0]      r_key, n_key;
    t_out_word        r_pend, n_pend;
    logic             r_ov, n_ov;
    t_out_word        r_out, n_out;

    logic [31:0]      r_mem [DEPTH];
    logic [31:0]      r_rd_data;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             out_free;
    logic             res_vld;
    t_out_word        res;
    logic             match;
    logic             more;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;
    assign out_free    = !r_ov || i_out_ready;
    assign match       = r_rd_vld && (r_rd_data == r_key);
    assign more        = (r_issue < r_count);

    // Element store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_in_word.value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Next-state logic
    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_count  = r_count;
        n_issue  = r_issue;
        n_rd_vld = 1'b0;
        n_key    = r_key;
        n_pend   = r_pend;
        n_ov     = r_ov;
        n_out    = r_out;
        wr_en    = 1'b0;
        wr_addr  = slot_at(r_front, r_count);
        rd_en    = 1'b0;
        rd_addr  = slot_at(r_front, r_issue);
        res_vld  = 1'b0;
        res      = '0;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    res_vld    = 1'b1;
                    res.status = ST_OK;
                    case (i_in_word.opcode)
                        OP_PUSH_FRONT: begin
                            if (r_count >= CNT_W'(DEPTH)) begin
                                res.status = ST_FULL;
                            end else begin
                                n_front = (r_front == '0) ? IDX_W'(DEPTH - 1)
                                                          : r_front - 1'b1;
                                wr_en   = 1'b1;
                                wr_addr = n_front;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (r_count >= CNT_W'(DEPTH)) begin
                                res.status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (r_count == '0) begin
                                res.status = ST_EMPTY;
                            end else begin
                                n_front = slot_at(r_front, CNT_W'(1));
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (r_count == '0) begin
                                res.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            res_vld = 1'b0;
                            n_key   = i_in_word.value;
                            n_issue = '0;
                            n_state = S_SEARCH;
                        end
                        default: begin
                        end
                    endcase
                    res.count    = 7'(n_count);
                    res.is_empty = (n_count == '0);
                end
            end
            S_SEARCH: begin
                // Walk front..front+count-1, compare one word per cycle
                if (match || (!more && !r_rd_vld)) begin
                    res_vld      = 1'b1;
                    res.status   = ST_OK;
                    res.found    = match;
                    res.count    = 7'(r_count);
                    res.is_empty = (r_count == '0);
                end else if (more) begin
                    rd_en   = 1'b1;
                    n_issue = r_issue + 1'b1;
                end
                n_rd_vld = rd_en;
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out   = r_pend;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Finished result: to output register, or park it
        if (res_vld) begin
            if (out_free) begin
                n_out   = res;
                n_ov    = 1'b1;
                n_state = S_IDLE;
            end else begin
                n_pend  = res;
                n_state = S_HOLD;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            r_ov     <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_issue <= n_issue;
        r_key   <= n_key;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

endmodule

@@ sim/tb_bounded_deque_with_search.sv @@
`timescale 1ns / 100ps

module tb_bounded_deque_with_search;
    import bdq_pkg::*;

    localparam int N_PHASE_WORDS = 580;
    localparam int TAIL_CYCLES   = 100;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    logic      out_ready  = 1'b0;
    t_in_word  in_word    = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    bounded_deque_with_search u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    // Words waiting to be driven, and results the deque owes us
    t_in_word  pending_words[$];
    t_out_word expected_results[$];

    int in_idle_pct  = 25;
    int out_idle_pct = 49;
    int words_queued = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int n_errors     = 0;
    int n_full       = 0;
    int n_empty_pops = 0;
    int n_hits       = 0;
    int n_misses     = 0;
    int max_depth    = 0;

    // Shadow deque
    logic signed [31:0] shadow_store [DEPTH];
    logic [IDX_W-1:0]   shadow_front = '0;
    logic [CNT_W-1:0]   shadow_count = '0;

    logic signed [31:0] value_pool [16];

    // Apply one word to the shadow deque and return the result it should give
    function automatic t_out_word deque_apply(t_in_word w);
        t_out_word r;
        int        pos;
        r = '0;
        r.status = ST_OK;
        case (w.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    if (w.opcode == OP_PUSH_FRONT) begin
                        shadow_front = (shadow_front == 0) ? IDX_W'(DEPTH - 1)
                                                           : shadow_front - 1'b1;
                        shadow_store[shadow_front] = w.value;
                    end else begin
                        pos = (int'(shadow_front) + int'(shadow_count)) % DEPTH;
                        shadow_store[pos] = w.value;
                    end
                    shadow_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                    n_empty_pops++;
                end else begin
                    if (w.opcode == OP_POP_FRONT)
                        shadow_front = IDX_W'((int'(shadow_front) + 1) % DEPTH);
                    shadow_count--;
                end
            end
            OP_SEARCH: begin
                for (int i = 0; i < int'(shadow_count); i++) begin
                    pos = (int'(shadow_front) + i) % DEPTH;
                    if (shadow_store[pos] == w.value) begin
                        r.found = 1'b1;
                        break;
                    end
                end
                if (r.found) n_hits++;
                else         n_misses++;
            end
            default: ;  // unused opcodes leave the state alone
        endcase
        r.count    = 7'(shadow_count);
        r.is_empty = (shadow_count == 0);
        if (int'(shadow_count) > max_depth) max_depth = int'(shadow_count);
        return r;
    endfunction

    // Driver: predict on acceptance, then offer the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_results.push_back(deque_apply(in_word));
                words_sent++;
            end
            if (!in_valid || o_in_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result word with no expectation: %p", o_out_word);
                    n_errors++;
                end else begin
                    exp_w = expected_results.pop_front();
                    if (o_out_word.status !== exp_w.status) begin
                        $error("status: expected %0d, got %0d", exp_w.status,
                               o_out_word.status);
                        n_errors++;
                    end
                    if (o_out_word.found !== exp_w.found) begin
                        $error("found: expected %0d, got %0d", exp_w.found,
                               o_out_word.found);
                        n_errors++;
                    end
                    if (o_out_word.count !== exp_w.count) begin
                        $error("count: expected %0d, got %0d", exp_w.count,
                               o_out_word.count);
                        n_errors++;
                    end
                    if (o_out_word.is_empty !== exp_w.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", exp_w.is_empty,
                               o_out_word.is_empty);
                        n_errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    task automatic queue_word(input logic [2:0] op, input logic signed [31:0] val);
        t_in_word w;
        w.opcode = op;
        w.value  = val;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Mostly pool values so searches hit, plus extremes and full-range noise
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            1, 2, 3: v = $urandom;
            default: v = value_pool[$urandom_range(15)];
        endcase
        return v;
    endfunction

    // One random word; push_pct / pop_pct steer the fill level
    task automatic queue_random_word(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            queue_word($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
        else if (r < push_pct + pop_pct)
            queue_word($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
        else if (r < 96)
            queue_word(OP_SEARCH, pick_value());
        else
            queue_word(3'(OP_SEARCH + $urandom_range(1, 3)), $urandom);
    endtask

    // Fill bursts, drain bursts and mixed traffic
    task automatic queue_random_phase(input int n_words);
        int goal;
        int len;
        goal = words_queued + n_words;
        while (words_queued < goal) begin
            case ($urandom_range(3))
                0: begin
                    len = $urandom_range(50, 90);
                    repeat (len) queue_random_word(85, 5);
                end
                1: begin
                    len = $urandom_range(50, 90);
                    repeat (len) queue_random_word(5, 85);
                end
                default: begin
                    len = $urandom_range(20, 60);
                    repeat (len) queue_random_word(35, 30);
                end
            endcase
        end
    endtask

    task automatic wait_queue_drained();
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus and end of run
    initial begin
        foreach (value_pool[i]) value_pool[i] = $urandom;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list cases, unused opcodes, extremes, front wrap
        queue_word(OP_POP_FRONT, 32'h1234_5678);
        queue_word(OP_POP_BACK, '1);
        queue_word(OP_SEARCH, '0);
        for (int k = 1; k <= 3; k++) queue_word(3'(OP_SEARCH + k), $urandom);
        queue_word(OP_PUSH_BACK, 32'h7fff_ffff);
        queue_word(OP_PUSH_FRONT, 32'h8000_0000);
        queue_word(OP_PUSH_BACK, '0);
        queue_word(OP_PUSH_FRONT, '1);
        queue_word(OP_SEARCH, 32'h8000_0000);
        queue_word(OP_SEARCH, 32'h7fff_ffff);
        queue_word(OP_SEARCH, 32'h1234_5678);
        queue_word(OP_POP_FRONT, '0);
        queue_word(OP_POP_BACK, '0);
        queue_word(OP_SEARCH, 32'h8000_0000);
        queue_word(OP_POP_FRONT, '0);
        queue_word(OP_POP_BACK, '0);
        queue_word(OP_POP_BACK, '0);
        queue_word(OP_PUSH_FRONT, 32'h5555_5555);
        queue_word(OP_PUSH_BACK, 32'haaaa_aaaa);
        queue_word(OP_SEARCH, 32'haaaa_aaaa);
        queue_word(OP_POP_FRONT, '0);
        queue_word(OP_POP_FRONT, '0);

        // Sender light idle, receiver heavy stall
        in_idle_pct  = 25;
        out_idle_pct = 49;
        queue_random_phase(N_PHASE_WORDS);
        wait_queue_drained();

        // Roles swapped
        in_idle_pct  = 49;
        out_idle_pct = 25;
        queue_random_phase(N_PHASE_WORDS);
        wait_queue_drained();

        // Full throughput
        in_idle_pct  = 0;
        out_idle_pct = 0;
        queue_random_phase(N_PHASE_WORDS);

        while (words_sent != words_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            n_errors++;
        end

        $display("Run covered %0d words, %0d results checked, peak fill %0d of %0d.",
                 words_sent, results_seen, max_depth, DEPTH);
        $display("Refused pushes %0d, pops on empty %0d, search hits %0d, misses %0d.",
                 n_full, n_empty_pops, n_hits, n_misses);
        if (n_errors == 0) begin
            $display("PASS bounded_deque_with_search");
        end else begin
            $display("FAIL bounded_deque_with_search");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(10_000_000);
        $display("FAIL bounded_deque_with_search");
        $finish;
    end

endmodule

@@ files.f @@
src/bdq_pkg.sv
src/bounded_deque_with_search.sv
sim/tb_bounded_deque_with_search.sv
